// ===== src/greedy_longest_match_tokenizer_defines.svh =====
// Assertion macros used by the checker file of the tokenizer.
`ifndef GREEDY_LONGEST_MATCH_TOKENIZER_DEFINES_SVH
`define GREEDY_LONGEST_MATCH_TOKENIZER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define GLMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed: same-cycle property");

// Property that must hold in the cycle after its trigger.
`define GLMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed: next-cycle property");

`endif

// ===== src/glmt_pkg.sv =====
package glmt_pkg;

    // Sizes of the vocabulary store and the lookahead window.
    localparam int VOCAB_ENTRIES = 4096;
    localparam int MAX_MATCH_LEN = 32;
    localparam int ENTRY_W       = $clog2(VOCAB_ENTRIES);
    localparam int SCAN_W        = $clog2(VOCAB_ENTRIES + 1);
    localparam int POS_W         = $clog2(MAX_MATCH_LEN);
    localparam int FILL_W        = $clog2(MAX_MATCH_LEN + 1);

    // Fixed field widths.
    localparam int ID_W    = 12;
    localparam int COUNT_W = 13;
    localparam int LIMIT_W = 16;
    localparam int LEN_W   = 6;

    // Input action codes.
    localparam logic ACTION_VOCAB = 1'b0;
    localparam logic ACTION_TEXT  = 1'b1;

    // Token kinds.
    localparam logic [1:0] KIND_BEGIN   = 2'd0;
    localparam logic [1:0] KIND_MATCH   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_VOCAB_COUNT  = 3'd0;
    localparam logic [2:0] REG_BEGIN_ID     = 3'd1;
    localparam logic [2:0] REG_END_ID       = 3'd2;
    localparam logic [2:0] REG_UNKNOWN_ID   = 3'd3;
    localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd4;

    typedef struct packed {
        logic        action;
        logic [11:0] vocab_entry;
        logic [4:0]  vocab_char_pos;
        logic [7:0]  vocab_char;
        logic [5:0]  vocab_entry_len;
        logic [7:0]  text_byte;
        logic        text_end;
    } t_in_item;

    typedef struct packed {
        logic [11:0] tok_id;
        logic [1:0]  token_kind;
        logic        run_last;
    } t_out_item;

    // Which token an emit command produces.
    typedef enum logic [1:0] {
        EMIT_BEGIN  = 2'd0,
        EMIT_DECIDE = 2'd1,
        EMIT_END    = 2'd2
    } t_emit_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      start_text;
        logic      end_text;
        logic      append;
        logic      strip;
        logic      scan_clear;
        logic      scan_run;
        logic      emit;
        t_emit_sel emit_sel;
        logic      drop_decide;
        logic      flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_text;
        logic text_end;
        logic fill_zero;
        logic fill_full;
        logic front_space;
        logic scan_done;
        logic emit_ok;
        logic flush_ok;
    } t_stat;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

endpackage

// ===== src/glmt_ctrl.sv =====
module glmt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_action,
    input  glmt_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output glmt_pkg::t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_BEGIN  = 10'b0000000010,
        S_OPEN   = 10'b0000000100,
        S_APPEND = 10'b0000001000,
        S_STRIP  = 10'b0000010000,
        S_CHECK  = 10'b0000100000,
        S_SCAN   = 10'b0001000000,
        S_DECIDE = 10'b0010000000,
        S_ENDTOK = 10'b0100000000,
        S_FLUSH  = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_sel = glmt_pkg::EMIT_BEGIN;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_action == glmt_pkg::ACTION_TEXT)) begin
                    n_state = S_BEGIN;
                end
            end
            S_BEGIN: begin
                if (i_stat.in_text) begin
                    n_state = S_APPEND;
                end else begin
                    o_cmd.start_text = 1'b1;
                    n_state = S_OPEN;
                end
            end
            S_OPEN: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = glmt_pkg::EMIT_BEGIN;
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state = S_STRIP;
            end
            S_STRIP: begin
                if (!i_stat.fill_zero && i_stat.front_space) begin
                    o_cmd.strip = 1'b1;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.text_end) begin
                    if (i_stat.fill_zero) begin
                        n_state = S_ENDTOK;
                    end else begin
                        o_cmd.scan_clear = 1'b1;
                        n_state = S_SCAN;
                    end
                end else if (i_stat.fill_full) begin
                    o_cmd.scan_clear = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_sel    = glmt_pkg::EMIT_DECIDE;
                    o_cmd.drop_decide = 1'b1;
                    n_state = S_STRIP;
                end
            end
            S_ENDTOK: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = glmt_pkg::EMIT_END;
                    o_cmd.end_text = 1'b1;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_stat.flush_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/glmt_dp.sv =====
module glmt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_acc,
    input  glmt_pkg::t_in_item                  i_in_data,
    input  logic [glmt_pkg::COUNT_W-1:0]        i_vocab_count,
    input  logic [glmt_pkg::ID_W-1:0]           i_begin_id,
    input  logic [glmt_pkg::ID_W-1:0]           i_end_id,
    input  logic [glmt_pkg::ID_W-1:0]           i_unknown_id,
    input  logic [glmt_pkg::LIMIT_W-1:0]        i_output_limit,
    input  glmt_pkg::t_cmd                      i_cmd,
    output glmt_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output glmt_pkg::t_out_item                 o_out_data
);

    localparam int MML = glmt_pkg::MAX_MATCH_LEN;

    // Vocabulary store: one row of bytes per entry, plus the entry lengths.
    logic [MML-1:0][7:0]           mem_bytes [glmt_pkg::VOCAB_ENTRIES];
    logic [glmt_pkg::LEN_W-1:0]    mem_lens  [glmt_pkg::VOCAB_ENTRIES];

    logic [MML-1:0][7:0]           r_rd_row;
    logic [glmt_pkg::LEN_W-1:0]    r_rd_len;
    logic [glmt_pkg::ENTRY_W-1:0]  r_rd_idx;
    logic                          r_rd_vld;
    logic [glmt_pkg::SCAN_W-1:0]   r_scan_idx;
    logic [glmt_pkg::SCAN_W-1:0]   scan_limit;
    logic                          scan_more;

    logic [glmt_pkg::FILL_W-1:0]   r_top_len;
    logic [glmt_pkg::ENTRY_W-1:0]  r_best_idx;

    logic [MML-1:0][7:0]           r_win;
    logic [glmt_pkg::FILL_W-1:0]   r_fill;
    logic [7:0]                    r_byte;
    logic                          r_end;
    logic                          r_in_text;
    logic [glmt_pkg::LIMIT_W-1:0]  r_count;

    logic                          r_pend_vld;
    logic [glmt_pkg::ID_W-1:0]     r_pend_id;
    logic [1:0]                    r_pend_kind;
    logic                          r_out_vld;
    glmt_pkg::t_out_item           r_out;

    logic                          vocab_wr;
    logic                          entry_hit;
    logic                          row_eq;
    logic [glmt_pkg::FILL_W-1:0]   drop_n;
    logic                          limit_hit;
    logic                          out_free;
    logic                          do_emit;
    logic                          push;
    logic [glmt_pkg::ID_W-1:0]     emit_id;
    logic [1:0]                    emit_kind;

    // Vocabulary writes happen on the transfer itself.
    assign vocab_wr = i_in_acc && (i_in_data.action == glmt_pkg::ACTION_VOCAB)
                      && ({1'b0, i_in_data.vocab_entry} < (glmt_pkg::ENTRY_W+1)'(glmt_pkg::VOCAB_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (vocab_wr) begin
            if ({1'b0, i_in_data.vocab_char_pos} < (glmt_pkg::POS_W+1)'(MML)) begin
                mem_bytes[i_in_data.vocab_entry[glmt_pkg::ENTRY_W-1:0]]
                         [i_in_data.vocab_char_pos[glmt_pkg::POS_W-1:0]] <= i_in_data.vocab_char;
            end
            mem_lens[i_in_data.vocab_entry[glmt_pkg::ENTRY_W-1:0]] <= i_in_data.vocab_entry_len;
        end
    end

    // Registered read of the entry under scan.
    always_ff @(posedge i_clk) begin
        r_rd_row <= mem_bytes[r_scan_idx[glmt_pkg::ENTRY_W-1:0]];
        r_rd_len <= mem_lens[r_scan_idx[glmt_pkg::ENTRY_W-1:0]];
        r_rd_idx <= r_scan_idx[glmt_pkg::ENTRY_W-1:0];
    end

    // Entries taking part are limited by the store depth.
    assign scan_limit = (i_vocab_count > glmt_pkg::COUNT_W'(glmt_pkg::VOCAB_ENTRIES))
                        ? glmt_pkg::SCAN_W'(glmt_pkg::VOCAB_ENTRIES)
                        : glmt_pkg::SCAN_W'(i_vocab_count);
    assign scan_more  = (r_scan_idx < scan_limit);

    // Masked compare of the read row against the window start.
    always_comb begin
        row_eq = 1'b1;
        for (int k = 0; k < MML; k++) begin
            if ((glmt_pkg::LEN_W'(k) < r_rd_len) && (r_rd_row[k] != r_win[k])) begin
                row_eq = 1'b0;
            end
        end
    end

    assign entry_hit = r_rd_vld && (r_rd_len != '0)
                       && (r_rd_len <= glmt_pkg::LEN_W'(r_fill))
                       && (r_rd_len > glmt_pkg::LEN_W'(r_top_len))
                       && row_eq;

    // Scan counter and best-match tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_scan_idx <= '0;
            r_top_len  <= '0;
            r_best_idx <= '0;
        end else if (i_cmd.scan_clear) begin
            r_rd_vld   <= 1'b0;
            r_scan_idx <= '0;
            r_top_len  <= '0;
            r_best_idx <= '0;
        end else if (i_cmd.scan_run) begin
            r_rd_vld <= scan_more;
            if (scan_more) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (entry_hit) begin
                r_top_len  <= glmt_pkg::FILL_W'(r_rd_len);
                r_best_idx <= r_rd_idx;
            end
        end
    end

    // Bytes removed from the window front.
    assign drop_n = (i_cmd.drop_decide && (r_top_len != '0)) ? r_top_len
                                                             : glmt_pkg::FILL_W'(1);

    // Window, fill level and text state.
    always_ff @(posedge i_clk) begin
        if (i_in_acc) begin
            r_byte <= i_in_data.text_byte;
            r_end  <= i_in_data.text_end;
        end
        if (i_cmd.append && (r_fill < glmt_pkg::FILL_W'(MML))) begin
            r_win[r_fill[glmt_pkg::POS_W-1:0]] <= r_byte;
        end else if (i_cmd.strip || i_cmd.drop_decide) begin
            r_win <= r_win >> {drop_n, 3'b000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_in_text <= 1'b0;
        end else begin
            if (i_cmd.start_text) begin
                r_fill    <= '0;
                r_in_text <= 1'b1;
            end else if (i_cmd.append && (r_fill < glmt_pkg::FILL_W'(MML))) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.strip || i_cmd.drop_decide) begin
                r_fill <= r_fill - drop_n;
            end
            if (i_cmd.end_text) begin
                r_in_text <= 1'b0;
            end
        end
    end

    // Token selection.
    always_comb begin
        case (i_cmd.emit_sel)
            glmt_pkg::EMIT_BEGIN: begin
                emit_id   = i_begin_id;
                emit_kind = glmt_pkg::KIND_BEGIN;
            end
            glmt_pkg::EMIT_END: begin
                emit_id   = i_end_id;
                emit_kind = glmt_pkg::KIND_END;
            end
            default: begin
                if (r_top_len != '0) begin
                    emit_id   = glmt_pkg::ID_W'(r_best_idx);
                    emit_kind = glmt_pkg::KIND_MATCH;
                end else begin
                    emit_id   = i_unknown_id;
                    emit_kind = glmt_pkg::KIND_UNKNOWN;
                end
            end
        endcase
    end

    // One token is held back so that the last one of an item can be flagged.
    assign limit_hit = (r_count >= i_output_limit);
    assign out_free  = !r_out_vld || i_out_ready;
    assign do_emit   = i_cmd.emit && !limit_hit;
    assign push      = r_pend_vld && (do_emit || i_cmd.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.start_text) begin
                r_count <= '0;
            end else if (do_emit) begin
                r_count <= r_count + 1'b1;
            end
            if (do_emit) begin
                r_pend_vld <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_vld <= 1'b0;
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_pend_id   <= emit_id;
            r_pend_kind <= emit_kind;
        end
        if (push) begin
            r_out.tok_id     <= r_pend_id;
            r_out.token_kind <= r_pend_kind;
            r_out.run_last   <= i_cmd.flush;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Status back to the controller.
    assign o_stat.in_text     = r_in_text;
    assign o_stat.text_end    = r_end;
    assign o_stat.fill_zero   = (r_fill == '0);
    assign o_stat.fill_full   = (r_fill >= glmt_pkg::FILL_W'(MML));
    assign o_stat.front_space = glmt_pkg::is_space(r_win[0]);
    assign o_stat.scan_done   = !scan_more && !r_rd_vld;
    assign o_stat.emit_ok     = limit_hit || !r_pend_vld || out_free;
    assign o_stat.flush_ok    = !r_pend_vld || out_free;

endmodule

// ===== src/greedy_longest_match_tokenizer.sv =====
// Greedy longest-match tokenizer. Vocabulary bytes are written through the input channel
// (one byte per transfer, no result). Text bytes fill a 32-byte window; leading
// whitespace is removed one byte per cycle, and each token decision scans the first
// min(vocab_count, 4096) entries of the vocabulary store, one entry per cycle through its
// single read port, before the emit. A text byte that does not fill the window costs no
// decision; one that fills it costs one decision, and the final byte of a text costs one
// decision per remaining token (up to 32). The vocabulary store is not cleared after
// reset: entries are to be read only once written, which the block does not enforce, as
// every entry below min(vocab_count, 4096) is scanned. Results leave through an output
// register, and the last result caused by a transfer carries run_last.
module greedy_longest_match_tokenizer (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  glmt_pkg::t_in_item     i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output glmt_pkg::t_out_item    o_out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [glmt_pkg::COUNT_W-1:0] r_vocab_count;
    logic [glmt_pkg::ID_W-1:0]    r_begin_id;
    logic [glmt_pkg::ID_W-1:0]    r_end_id;
    logic [glmt_pkg::ID_W-1:0]    r_unknown_id;
    logic [glmt_pkg::LIMIT_W-1:0] r_output_limit;
    logic                         cfg_wr;
    logic [2:0]                   reg_idx;
    logic                         in_acc;
    glmt_pkg::t_cmd               cmd;
    glmt_pkg::t_stat              stat;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vocab_count  <= '0;
            r_begin_id     <= '0;
            r_end_id       <= '0;
            r_unknown_id   <= '0;
            r_output_limit <= glmt_pkg::LIMIT_W'(256);
        end else if (cfg_wr) begin
            case (reg_idx)
                glmt_pkg::REG_VOCAB_COUNT:  r_vocab_count  <= pwdata[glmt_pkg::COUNT_W-1:0];
                glmt_pkg::REG_BEGIN_ID:     r_begin_id     <= pwdata[glmt_pkg::ID_W-1:0];
                glmt_pkg::REG_END_ID:       r_end_id       <= pwdata[glmt_pkg::ID_W-1:0];
                glmt_pkg::REG_UNKNOWN_ID:   r_unknown_id   <= pwdata[glmt_pkg::ID_W-1:0];
                glmt_pkg::REG_OUTPUT_LIMIT: r_output_limit <= pwdata[glmt_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            glmt_pkg::REG_VOCAB_COUNT:  prdata = 32'(r_vocab_count);
            glmt_pkg::REG_BEGIN_ID:     prdata = 32'(r_begin_id);
            glmt_pkg::REG_END_ID:       prdata = 32'(r_end_id);
            glmt_pkg::REG_UNKNOWN_ID:   prdata = 32'(r_unknown_id);
            glmt_pkg::REG_OUTPUT_LIMIT: prdata = 32'(r_output_limit);
            default:                    prdata = '0;
        endcase
    end

    assign in_acc = i_in_valid && o_in_ready;

    glmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    glmt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_acc       (in_acc),
        .i_in_data      (i_in_data),
        .i_vocab_count  (r_vocab_count),
        .i_begin_id     (r_begin_id),
        .i_end_id       (r_end_id),
        .i_unknown_id   (r_unknown_id),
        .i_output_limit (r_output_limit),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_data     (o_out_data)
    );

endmodule

// ===== src/glmt_checker.sv =====
`include "greedy_longest_match_tokenizer_defines.svh"

module glmt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input glmt_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input glmt_pkg::t_out_item o_out_data
);

    // An end token always closes the results of its transfer.
`GLMT_ASSERT_SAME(a_end_is_last, i_clk, i_rst_n, o_out_valid && (o_out_data.token_kind == glmt_pkg::KIND_END), o_out_data.run_last)

    // A text byte keeps the input closed while it is being worked on.
`GLMT_ASSERT_NEXT(a_text_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_data.action == glmt_pkg::ACTION_TEXT), !o_in_ready)

    // A stalled result stays put.
`GLMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind greedy_longest_match_tokenizer glmt_checker u_glmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== verif/tb_greedy_longest_match_tokenizer.sv =====
module tb_greedy_longest_match_tokenizer;

    // Token stream predictor and the queue of tokens still owed by the block.
    class token_scoreboard;
        logic [7:0]  vocab_store [int];
        logic [5:0]  vocab_len [int];
        logic [7:0]  window [$];
        int unsigned emitted;
        bit          text_open;
        logic [12:0] vocab_count;
        logic [11:0] begin_id;
        logic [11:0] end_id;
        logic [11:0] unknown_id;
        logic [15:0] output_limit;
        glmt_pkg::t_out_item pending [$];
        int          mismatches;

        function new();
            vocab_count  = '0;
            begin_id     = '0;
            end_id       = '0;
            unknown_id   = '0;
            output_limit = 16'd256;
            emitted      = 0;
            text_open    = 0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                glmt_pkg::REG_VOCAB_COUNT:  vocab_count  = value[12:0];
                glmt_pkg::REG_BEGIN_ID:     begin_id     = value[11:0];
                glmt_pkg::REG_END_ID:       end_id       = value[11:0];
                glmt_pkg::REG_UNKNOWN_ID:   unknown_id   = value[11:0];
                glmt_pkg::REG_OUTPUT_LIMIT: output_limit = value[15:0];
                default: ;
            endcase
        endfunction

        function bit is_ws(logic [7:0] c);
            return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function void push_token(logic [11:0] id, logic [1:0] kind,
                                 ref glmt_pkg::t_out_item run [$]);
            glmt_pkg::t_out_item t;
            if (emitted >= output_limit) return;
            t.tok_id     = id;
            t.token_kind = kind;
            t.run_last   = 1'b0;
            run.push_back(t);
            emitted++;
        endfunction

        function void trim_space();
            while (window.size() > 0 && is_ws(window[0])) void'(window.pop_front());
        endfunction

        // One token decision: longest fitting entry, lowest index on a tie.
        function void pick_token(ref glmt_pkg::t_out_item run [$]);
            int lim;
            int top_len;
            int best_idx;
            int l;
            bit hit;
            lim = (vocab_count < glmt_pkg::VOCAB_ENTRIES) ? int'(vocab_count)
                                                          : glmt_pkg::VOCAB_ENTRIES;
            top_len  = 0;
            best_idx = 0;
            for (int i = 0; i < lim; i++) begin
                l = vocab_len.exists(i) ? int'(vocab_len[i]) : 0;
                if (l == 0 || l > window.size() || l <= top_len) continue;
                hit = 1;
                for (int k = 0; k < l; k++) begin
                    if (window[k] != (vocab_store.exists(i * 32 + k) ?
                                      vocab_store[i * 32 + k] : 8'd0)) begin
                        hit = 0;
                        break;
                    end
                end
                if (hit) begin
                    top_len  = l;
                    best_idx = i;
                end
            end
            if (top_len > 0) begin
                push_token(best_idx[11:0], glmt_pkg::KIND_MATCH, run);
                repeat (top_len) void'(window.pop_front());
            end else begin
                push_token(unknown_id, glmt_pkg::KIND_UNKNOWN, run);
                void'(window.pop_front());
            end
            trim_space();
        endfunction

        // Note one accepted input transfer.
        function void note_input(glmt_pkg::t_in_item it);
            glmt_pkg::t_out_item run [$];
            if (it.action == glmt_pkg::ACTION_VOCAB) begin
                vocab_store[it.vocab_entry * 32 + it.vocab_char_pos] = it.vocab_char;
                vocab_len[it.vocab_entry] = it.vocab_entry_len;
                return;
            end
            if (!text_open) begin
                text_open = 1;
                window.delete();
                emitted = 0;
                push_token(begin_id, glmt_pkg::KIND_BEGIN, run);
            end
            if (window.size() < glmt_pkg::MAX_MATCH_LEN) window.push_back(it.text_byte);
            trim_space();
            if (it.text_end) begin
                while (window.size() > 0) pick_token(run);
                push_token(end_id, glmt_pkg::KIND_END, run);
                text_open = 0;
            end else if (window.size() >= glmt_pkg::MAX_MATCH_LEN) begin
                pick_token(run);
            end
            if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
            foreach (run[i]) pending.push_back(run[i]);
        endfunction

        // Check one accepted result transfer.
        function void check_token(glmt_pkg::t_out_item got);
            glmt_pkg::t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected token %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("token mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    glmt_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    glmt_pkg::t_out_item o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [4:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    token_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  quiet_cycles;
    bit  timed_out;
    int  entries_loaded;

    greedy_longest_match_tokenizer dut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: random stalls, long hold-off on request, and checking.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_token(o_out_data);
        i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("tb_greedy_longest_match_tokenizer NOT OK");
            $finish;
        end
    end

    // One register write: setup phase, access phase, then the bus returns to idle.
    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Offer one item and hold it until the transfer.
    task automatic send_item(glmt_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic send_vocab(int entry, int pos, logic [7:0] c, int len);
        glmt_pkg::t_in_item it;
        it = '0;
        it.action          = glmt_pkg::ACTION_VOCAB;
        it.vocab_entry     = 12'(entry);
        it.vocab_char_pos  = 5'(pos);
        it.vocab_char      = c;
        it.vocab_entry_len = 6'(len);
        it.text_byte       = 8'($urandom);
        it.text_end        = 1'($urandom);
        send_item(it);
    endtask

    task automatic send_text(logic [7:0] b, bit last);
        glmt_pkg::t_in_item it;
        it = '0;
        it.action          = glmt_pkg::ACTION_TEXT;
        it.text_byte       = b;
        it.text_end        = last;
        it.vocab_entry     = 12'($urandom);
        it.vocab_char_pos  = 5'($urandom);
        it.vocab_char      = 8'($urandom);
        it.vocab_entry_len = 6'($urandom);
        send_item(it);
    endtask

    // Write a whole entry; bytes come from a small alphabet so matches are common.
    task automatic load_entry(int entry, int len);
        for (int p = 0; p < (len == 0 ? 1 : len); p++)
            send_vocab(entry, p, 8'(8'h61 + $urandom_range(3)), len);
    endtask

    function automatic logic [7:0] rand_text_byte();
        case ($urandom_range(9))
            0: return 8'd32;
            1: return 8'($urandom_range(13, 9));
            2: return 8'($urandom);
            default: return 8'(8'h61 + $urandom_range(3));
        endcase
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4200) @(posedge i_clk);
    endtask

    task automatic send_text_run(int len);
        for (int k = 0; k < len; k++) send_text(rand_text_byte(), k == len - 1);
    endtask

    initial begin
        sb = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 0;
        quiet_cycles   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: small vocabulary with overlapping prefixes.
        cfg_write(glmt_pkg::REG_VOCAB_COUNT, 32'd8);
        cfg_write(glmt_pkg::REG_BEGIN_ID, 32'hFFF);
        cfg_write(glmt_pkg::REG_END_ID, 32'h000);
        cfg_write(glmt_pkg::REG_UNKNOWN_ID, 32'hABC);
        cfg_write(glmt_pkg::REG_OUTPUT_LIMIT, 32'hFFFF);
        send_vocab(0, 0, 8'h61, 1);
        send_vocab(1, 0, 8'h61, 2);
        send_vocab(1, 1, 8'h62, 2);
        send_vocab(2, 0, 8'h61, 2);
        send_vocab(2, 1, 8'h62, 2);
        send_vocab(3, 0, 8'hFF, 0);
        send_vocab(4, 31, 8'h00, 32);
        for (int e = 5; e < 8; e++) load_entry(e, e - 4);
        send_vocab(4095, 0, 8'hFF, 63);
        // Tie, whitespace, unknown byte, and a lone byte text.
        send_text(8'd32, 0);
        send_text(8'h61, 0);
        send_text(8'h62, 0);
        send_text(8'd9, 0);
        send_text(8'hFF, 1);
        send_text(8'd13, 1);
        send_text(8'h00, 1);
        wait_drained();

        // Token limit and empty-table extremes.
        cfg_write(glmt_pkg::REG_OUTPUT_LIMIT, 32'd2);
        cfg_write(glmt_pkg::REG_VOCAB_COUNT, 32'd0);
        send_text_run(5);
        wait_drained();
        cfg_write(glmt_pkg::REG_OUTPUT_LIMIT, 32'd0);
        send_text_run(3);
        wait_drained();

        // Random part over several idle settings on a small table.
        cfg_write(glmt_pkg::REG_OUTPUT_LIMIT, 32'd256);
        entries_loaded = 12;
        for (int e = 0; e < entries_loaded; e++) load_entry(e, $urandom_range(1, 4));
        wait_drained();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            cfg_write(glmt_pkg::REG_VOCAB_COUNT, 32'(entries_loaded));
            cfg_write(glmt_pkg::REG_BEGIN_ID, $urandom);
            cfg_write(glmt_pkg::REG_END_ID, $urandom);
            cfg_write(glmt_pkg::REG_UNKNOWN_ID, $urandom);
            cfg_write(glmt_pkg::REG_OUTPUT_LIMIT, ph == 1 ? 32'd4 : 32'd256);
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps pushing.
                recv_hold = 1;
                fork
                    begin
                        repeat (3000) @(posedge i_clk);
                        recv_hold = 0;
                    end
                join_none
            end
            for (int t = 0; t < 2; t++) begin
                int ent;
                int elen;
                // Rewrite a byte inside an entry, keeping its length.
                if ($urandom_range(3) == 0) begin
                    ent  = $urandom_range(entries_loaded - 1);
                    elen = sb.vocab_len[ent];
                    send_vocab(ent, $urandom_range(elen - 1),
                               8'(8'h61 + $urandom_range(3)), elen);
                end
                send_text_run((ph == 0 && t == 0) ? 40 : $urandom_range(3, 8));
            end
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_greedy_longest_match_tokenizer OK");
        else
            $display("tb_greedy_longest_match_tokenizer NOT OK");
        $finish;
    end
endmodule
